// File: hdl/ipv6p_pkg.sv
// ----------------------------------------------------------------------------
// ipv6p_pkg
// Shared types and constants for the IPv6 text address parser.
// ----------------------------------------------------------------------------
package ipv6p_pkg;

  localparam int GROUP_SLOTS   = 8;
  localparam int SLOT_W        = $clog2(GROUP_SLOTS);
  localparam int CNT_W         = 4;
  localparam int MAX_TEXT_DEF  = 63;

  localparam logic [CNT_W-1:0] COUNT_CAP   = 4'd9;
  localparam logic [CNT_W-1:0] SLOT_LIMIT  = 4'd8;
  localparam logic [7:0]       CHAR_COLON  = 8'h3A;
  localparam logic [15:0]      LL_MASK     = 16'hFFC0;
  localparam logic [15:0]      LL_PREFIX   = 16'hFE80;

  typedef logic [15:0] group_t;

  // group lists as they stand once the current character is taken
  typedef struct packed {
    logic                              compressed;
    group_t [GROUP_SLOTS-1:0]          plain;
    logic   [CNT_W-1:0]                plain_cnt;
    group_t [GROUP_SLOTS-1:0]          left;
    logic   [CNT_W-1:0]                left_cnt;
    group_t [GROUP_SLOTS-1:0]          right;
    logic   [CNT_W-1:0]                right_cnt;
  } scan_view_t;

endpackage

// File: hdl/ipv6p_scan.sv
// ----------------------------------------------------------------------------
// ipv6p_scan
// Per-character tokeniser: tracks the current token and the plain, left and
// right group lists, one character per cycle while take is high.
// ----------------------------------------------------------------------------
module ipv6p_scan #(
  parameter int MAX_TEXT_CHARS = ipv6p_pkg::MAX_TEXT_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   take,
  input  logic [7:0]             chr,
  input  logic                   last,
  output ipv6p_pkg::scan_view_t  view
);
  import ipv6p_pkg::*;

  localparam int CHAR_W = $clog2(MAX_TEXT_CHARS + 1);

  logic [CHAR_W-1:0]        char_cnt_r, char_cnt_nxt;
  logic                     comp_r, comp_nxt;
  logic                     prev_r, prev_nxt;
  group_t                   tval_r, tval_nxt;
  logic                     tne_r, tne_nxt;
  logic                     tstop_r, tstop_nxt;
  group_t [GROUP_SLOTS-1:0] plain_r, plain_nxt;
  group_t [GROUP_SLOTS-1:0] left_r, left_nxt;
  group_t [GROUP_SLOTS-1:0] right_r, right_nxt;
  logic   [CNT_W-1:0]       plain_cnt_r, plain_cnt_nxt;
  logic   [CNT_W-1:0]       left_cnt_r, left_cnt_nxt;
  logic   [CNT_W-1:0]       right_cnt_r, right_cnt_nxt;

  logic       active, is_colon, dbl, close_col, close_fin, any_close;
  logic       ne_c, push_p, push_l, push_r;
  group_t     v_c;
  logic [4:0] hex;

  // {valid, digit}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39)      r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

  always_comb begin
    active   = char_cnt_r < CHAR_W'(MAX_TEXT_CHARS);
    is_colon = chr == CHAR_COLON;
    hex      = hex_digit(chr);
    dbl      = active && is_colon && !comp_r && prev_r;

    char_cnt_nxt = active ? char_cnt_r + 1'b1 : char_cnt_r;
    comp_nxt     = comp_r | dbl;
    prev_nxt     = active ? is_colon : prev_r;
    tval_nxt     = tval_r;
    tne_nxt      = tne_r;
    tstop_nxt    = tstop_r;
    if (active && is_colon) begin
      tval_nxt  = '0;
      tne_nxt   = 1'b0;
      tstop_nxt = 1'b0;
    end else if (active) begin
      tne_nxt = 1'b1;
      if (!tstop_r) begin
        if (hex[4]) tval_nxt = {tval_r[11:0], hex[3:0]};
        else        tstop_nxt = 1'b1;
      end
    end

    // a colon closes the old token; the last character closes the new one
    // (after a colon the token is empty, so both never push together)
    close_col = active && is_colon && !dbl;
    close_fin = last && !(active && is_colon);
    any_close = close_col || close_fin;
    ne_c      = close_col ? tne_r : tne_nxt;
    v_c       = close_col ? tval_r : tval_nxt;
    push_r    = any_close && comp_r && ne_c;
    push_l    = any_close && !comp_r && ne_c;
    push_p    = any_close && !comp_r && (ne_c || close_col);

    plain_nxt     = plain_r;
    left_nxt      = left_r;
    right_nxt     = right_r;
    plain_cnt_nxt = plain_cnt_r;
    left_cnt_nxt  = left_cnt_r;
    right_cnt_nxt = right_cnt_r;
    if (push_p) begin
      if (plain_cnt_r < SLOT_LIMIT) plain_nxt[plain_cnt_r[SLOT_W-1:0]] = v_c;
      if (plain_cnt_r < COUNT_CAP)  plain_cnt_nxt = plain_cnt_r + 1'b1;
    end
    if (push_l) begin
      if (left_cnt_r < SLOT_LIMIT) left_nxt[left_cnt_r[SLOT_W-1:0]] = v_c;
      if (left_cnt_r < COUNT_CAP)  left_cnt_nxt = left_cnt_r + 1'b1;
    end
    if (push_r) begin
      if (right_cnt_r < SLOT_LIMIT) right_nxt[right_cnt_r[SLOT_W-1:0]] = v_c;
      if (right_cnt_r < COUNT_CAP)  right_cnt_nxt = right_cnt_r + 1'b1;
    end

    view.compressed = comp_nxt;
    view.plain      = plain_nxt;
    view.plain_cnt  = plain_cnt_nxt;
    view.left       = left_nxt;
    view.left_cnt   = left_cnt_nxt;
    view.right      = right_nxt;
    view.right_cnt  = right_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_cnt_r  <= '0;
      comp_r      <= 1'b0;
      prev_r      <= 1'b0;
      tval_r      <= '0;
      tne_r       <= 1'b0;
      tstop_r     <= 1'b0;
      plain_cnt_r <= '0;
      left_cnt_r  <= '0;
      right_cnt_r <= '0;
    end else if (take) begin
      if (last) begin
        char_cnt_r  <= '0;
        comp_r      <= 1'b0;
        prev_r      <= 1'b0;
        tval_r      <= '0;
        tne_r       <= 1'b0;
        tstop_r     <= 1'b0;
        plain_cnt_r <= '0;
        left_cnt_r  <= '0;
        right_cnt_r <= '0;
      end else begin
        char_cnt_r  <= char_cnt_nxt;
        comp_r      <= comp_nxt;
        prev_r      <= prev_nxt;
        tval_r      <= tval_nxt;
        tne_r       <= tne_nxt;
        tstop_r     <= tstop_nxt;
        plain_cnt_r <= plain_cnt_nxt;
        left_cnt_r  <= left_cnt_nxt;
        right_cnt_r <= right_cnt_nxt;
      end
    end
  end

  // group stores hold payload only
  always_ff @(posedge clk) begin
    if (take) begin
      plain_r <= plain_nxt;
      left_r  <= left_nxt;
      right_r <= right_nxt;
    end
  end

endmodule

// File: hdl/ipv6p_assemble.sv
// ----------------------------------------------------------------------------
// ipv6p_assemble
// Builds the 128-bit address and flags from the closed group lists.
// ----------------------------------------------------------------------------
module ipv6p_assemble (
  input  ipv6p_pkg::scan_view_t view,
  output logic [63:0]           addr_high,
  output logic [63:0]           addr_low,
  output logic                  parse_ok,
  output logic                  is_loopback,
  output logic                  is_link_local
);
  import ipv6p_pkg::*;

  group_t [GROUP_SLOTS-1:0] g;
  logic   [4:0]             total;
  logic   [4:0]             pos;
  logic                     ok;
  logic                     upper_zero;

  always_comb begin
    total = {1'b0, view.left_cnt} + {1'b0, view.right_cnt};
    ok    = view.compressed ? (total <= 5'(GROUP_SLOTS))
                            : (view.plain_cnt == SLOT_LIMIT);
    g = '0;
    for (int i = 0; i < GROUP_SLOTS; i++) begin
      // right groups end at slot 7: slot i holds right entry i + count - 8
      pos = 5'(i) + {1'b0, view.right_cnt};
      if (ok) begin
        if (view.compressed) begin
          if (5'(i) < {1'b0, view.left_cnt}) g[i] = view.left[i];
          else if (pos >= 5'(GROUP_SLOTS))   g[i] = view.right[pos[SLOT_W-1:0]];
        end else begin
          g[i] = view.plain[i];
        end
      end
    end

    upper_zero = 1'b1;
    for (int i = 0; i < GROUP_SLOTS - 1; i++) begin
      if (g[i] != '0) upper_zero = 1'b0;
    end

    addr_high     = {g[0], g[1], g[2], g[3]};
    addr_low      = {g[4], g[5], g[6], g[7]};
    parse_ok      = ok;
    is_loopback   = upper_zero && (g[GROUP_SLOTS-1] == 16'd1);
    is_link_local = (g[0] & LL_MASK) == LL_PREFIX;
  end

endmodule

// File: hdl/ipv6_text_address_parser_unit.sv
// ----------------------------------------------------------------------------
// ipv6_text_address_parser_unit
// IPv6 text address parser: one character per request, one result per text.
// ----------------------------------------------------------------------------
// Characters are taken at one per cycle while in_stall is low. Each request is
// registered, then passes through the tokeniser, and on the character marked
// last the closed group lists are assembled into the address in the same
// cycle as the tokeniser update, and the result is registered. Only a last
// character waits for the result register to be free; other characters flow
// on regardless of the output side.
module ipv6_text_address_parser_unit #(
  parameter int MAX_TEXT_CHARS = ipv6p_pkg::MAX_TEXT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_text_char,
  input  logic        in_last_char,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_addr_high,
  output logic [63:0] out_addr_low,
  output logic        out_parse_ok,
  output logic        out_is_loopback,
  output logic        out_is_link_local
);
  import ipv6p_pkg::*;

  logic        s1_valid_r;
  logic [7:0]  s1_char_r;
  logic        s1_last_r;
  logic        s1_go, take, in_take;
  scan_view_t  view;
  logic [63:0] res_high, res_low;
  logic        res_ok, res_loop, res_ll;

  logic        out_valid_r;
  logic [63:0] out_high_r, out_low_r;
  logic        out_ok_r, out_loop_r, out_ll_r;

  // a last character needs room in the result register
  assign s1_go    = !s1_last_r || !out_valid_r || !out_stall;
  assign take     = s1_valid_r && s1_go;
  assign in_stall = s1_valid_r && !s1_go;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (take) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_char_r <= in_text_char;
      s1_last_r <= in_last_char;
    end
  end

  ipv6p_scan #(
    .MAX_TEXT_CHARS(MAX_TEXT_CHARS)
  ) u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .chr   (s1_char_r),
    .last  (s1_last_r),
    .view  (view)
  );

  ipv6p_assemble u_assemble (
    .view          (view),
    .addr_high     (res_high),
    .addr_low      (res_low),
    .parse_ok      (res_ok),
    .is_loopback   (res_loop),
    .is_link_local (res_ll)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && s1_last_r) begin
      out_high_r <= res_high;
      out_low_r  <= res_low;
      out_ok_r   <= res_ok;
      out_loop_r <= res_loop;
      out_ll_r   <= res_ll;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_addr_high     = out_high_r;
  assign out_addr_low      = out_low_r;
  assign out_parse_ok      = out_ok_r;
  assign out_is_loopback   = out_loop_r;
  assign out_is_link_local = out_ll_r;

endmodule

// File: verif/tb_ipv6_text_address_parser_unit.sv
// ----------------------------------------------------------------------------
// tb_ipv6_text_address_parser_unit
// Self-checking bench for the IPv6 text address parser.
// ----------------------------------------------------------------------------
// Address texts are queued up front. There is a short directed set, then
// random texts that are mostly well-formed (plain and compressed, with random
// digits, case, over-long tokens and junk) and partly noise. A clocked driver
// sends one character per request, with random gaps. A clocked monitor checks
// every result against an address that the bench scans itself from the
// accepted characters. The result side stalls at random.
module tb_ipv6_text_address_parser_unit;
  import ipv6p_pkg::*;

  localparam int TEXT_LIMIT    = MAX_TEXT_DEF;
  localparam int RANDOM_CHARS  = 1420;
  localparam int IDLE_LIMIT    = 2000;
  localparam int DRAIN_EVERY   = 25;
  localparam int TAIL_CYCLES   = 8;
  localparam int REPORT_LIMIT  = 10;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_LO_A = 8'h61;
  localparam logic [7:0] CH_UP_A = 8'h41;
  localparam logic [7:0] CH_ONE  = 8'h31;
  localparam logic [7:0] CH_E    = 8'h65;
  localparam logic [7:0] CH_F    = 8'h66;
  localparam logic [7:0] CH_Z    = 8'h7A;
  localparam logic [7:0] CH_NINE = 8'h39;

  typedef enum logic [1:0] {LIST_PLAIN, LIST_LEFT, LIST_RIGHT} group_list_t;

  typedef struct {
    logic [7:0] ch;
    logic       last;
    bit         drain_first;
  } char_req_t;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
    logic        ok;
    logic        loopback;
    logic        link_local;
  } addr_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_text_char = 8'h20;
  logic        in_last_char = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_addr_high;
  logic [63:0] out_addr_low;
  logic        out_parse_ok;
  logic        out_is_loopback;
  logic        out_is_link_local;

  ipv6_text_address_parser_unit uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_text_char     (in_text_char),
    .in_last_char     (in_last_char),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_addr_high    (out_addr_high),
    .out_addr_low     (out_addr_low),
    .out_parse_ok     (out_parse_ok),
    .out_is_loopback  (out_is_loopback),
    .out_is_link_local(out_is_link_local)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  char_req_t    char_queue[$];
  addr_result_t pending_addrs[$];
  addr_result_t front_addr;
  logic [7:0]   scratch[$];

  // scanner state, mirrors what the block keeps per text
  int     chars_seen;
  bit     after_double_colon;
  bit     last_was_colon;
  group_t token_val;
  bit     token_has_chars;
  bit     token_halted;
  group_t plain_list [GROUP_SLOTS];
  group_t left_list  [GROUP_SLOTS];
  group_t right_list [GROUP_SLOTS];
  int     plain_n, left_n, right_n;

  int  mismatch_count, results_seen, texts_scanned, ok_texts, loop_texts, ll_texts;
  int  idle_cycles, hold_cycles, stall_left;
  bit  req_taken, in_steady, out_steady, timed_out;

  // ---------------------------------------------------------------- scanner
  function automatic int hex_digit(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 8'h30;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 8'h61 + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 8'h41 + 10;
    return -1;
  endfunction

  task automatic clear_scan();
    chars_seen = 0;
    after_double_colon = 0;
    last_was_colon = 0;
    token_val = '0;
    token_has_chars = 0;
    token_halted = 0;
    plain_n = 0;
    left_n = 0;
    right_n = 0;
  endtask

  task automatic append_group(input group_list_t which, input group_t v);
    case (which)
      LIST_PLAIN: begin
        if (plain_n < GROUP_SLOTS) plain_list[plain_n] = v;
        if (plain_n < COUNT_CAP) plain_n++;
      end
      LIST_LEFT: begin
        if (left_n < GROUP_SLOTS) left_list[left_n] = v;
        if (left_n < COUNT_CAP) left_n++;
      end
      default: begin
        if (right_n < GROUP_SLOTS) right_list[right_n] = v;
        if (right_n < COUNT_CAP) right_n++;
      end
    endcase
  endtask

  // a trailing empty token only drops out of the plain count
  task automatic close_token(input bit at_end);
    if (after_double_colon) begin
      if (token_has_chars) append_group(LIST_RIGHT, token_val);
    end else begin
      if (token_has_chars || !at_end) append_group(LIST_PLAIN, token_val);
      if (token_has_chars) append_group(LIST_LEFT, token_val);
    end
    token_val = '0;
    token_has_chars = 0;
    token_halted = 0;
  endtask

  task automatic scan_char(input logic [7:0] c, input logic last);
    addr_result_t res;
    group_t       g [GROUP_SLOTS];
    int           d;
    if (chars_seen < TEXT_LIMIT) begin
      chars_seen++;
      if (c == CHAR_COLON) begin
        if (!after_double_colon && last_was_colon) begin
          after_double_colon = 1;
          token_val = '0;
          token_has_chars = 0;
          token_halted = 0;
        end else begin
          close_token(1'b0);
        end
        last_was_colon = 1;
      end else begin
        last_was_colon = 0;
        token_has_chars = 1;
        if (!token_halted) begin
          d = hex_digit(c);
          if (d < 0) token_halted = 1;
          else token_val = {token_val[11:0], 4'(d)};
        end
      end
    end
    if (last) begin
      close_token(1'b1);
      foreach (g[i]) g[i] = '0;
      if (after_double_colon) begin
        res.ok = (left_n + right_n <= GROUP_SLOTS);
        if (res.ok) begin
          for (int i = 0; i < left_n; i++) g[i] = left_list[i];
          for (int i = 0; i < right_n; i++) g[GROUP_SLOTS - right_n + i] = right_list[i];
        end
      end else begin
        res.ok = (plain_n == GROUP_SLOTS);
        if (res.ok) foreach (g[i]) g[i] = plain_list[i];
      end
      res.hi = {g[0], g[1], g[2], g[3]};
      res.lo = {g[4], g[5], g[6], g[7]};
      res.loopback = (res.hi == 64'd0 && res.lo == 64'd1);
      res.link_local = ((g[0] & LL_MASK) == LL_PREFIX);
      pending_addrs.push_back(res);
      texts_scanned++;
      ok_texts += res.ok;
      loop_texts += res.loopback;
      ll_texts += res.link_local;
      clear_scan();
    end
  endtask

  // --------------------------------------------------------- text building
  function automatic logic [7:0] hex_char(input int v, input bit up);
    if (v < 10) return CH_ZERO + 8'(v);
    return (up ? CH_UP_A : CH_LO_A) + 8'(v - 10);
  endfunction

  function automatic logic [7:0] junk_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == CHAR_COLON);
    return c;
  endfunction

  task automatic queue_scratch(input bit drain);
    char_req_t r;
    foreach (scratch[i]) begin
      r.ch = scratch[i];
      r.last = (i == scratch.size() - 1);
      r.drain_first = drain && (i == 0);
      char_queue.push_back(r);
    end
  endtask

  task automatic add_text(input string s, input bit drain);
    scratch.delete();
    for (int i = 0; i < s.len(); i++) scratch.push_back(s[i]);
    queue_scratch(drain);
  endtask

  task automatic put_hex_token();
    int n;
    bit up;
    n = ($urandom_range(99) < 8) ? $urandom_range(5, 6) : $urandom_range(1, 4);
    up = $urandom_range(1);
    repeat (n) scratch.push_back(hex_char($urandom_range(15), up ^ ($urandom_range(9) == 0)));
    // stopped token: junk then digits, ignored unless the junk is itself a hex digit
    if ($urandom_range(19) == 0) begin
      scratch.push_back(junk_char());
      repeat ($urandom_range(2)) scratch.push_back(hex_char($urandom_range(15), up));
    end
  endtask

  // leading group sometimes lands around the link-local prefix
  task automatic put_first_token();
    if ($urandom_range(9) == 0) begin
      scratch.push_back(CH_F);
      scratch.push_back(CH_E);
      scratch.push_back(hex_char($urandom_range(8, 12), $urandom_range(1)));
      scratch.push_back(hex_char($urandom_range(15), $urandom_range(1)));
    end else begin
      put_hex_token();
    end
  endtask

  task automatic gen_well_formed();
    int r, total, left_part;
    scratch.delete();
    r = $urandom_range(99);
    if (r < 3) begin
      scratch = '{CHAR_COLON, CHAR_COLON, CH_ONE};
    end else if (r < 45) begin
      total = ($urandom_range(9) == 0) ? $urandom_range(6, 10) : GROUP_SLOTS;
      for (int i = 0; i < total; i++) begin
        if (i > 0) scratch.push_back(CHAR_COLON);
        if ($urandom_range(11) != 0) begin
          if (i == 0) put_first_token();
          else put_hex_token();
        end
      end
      if ($urandom_range(14) == 0) scratch.push_back(CHAR_COLON);
    end else begin
      total = ($urandom_range(9) == 0) ? $urandom_range(8, 10) : $urandom_range(0, 7);
      left_part = $urandom_range(total);
      for (int i = 0; i < left_part; i++) begin
        if (i > 0) scratch.push_back(CHAR_COLON);
        if (i == 0) put_first_token();
        else put_hex_token();
      end
      scratch.push_back(CHAR_COLON);
      scratch.push_back(CHAR_COLON);
      for (int i = 0; i < total - left_part; i++) begin
        if (i > 0) scratch.push_back(CHAR_COLON);
        put_hex_token();
      end
      if ($urandom_range(19) == 0) begin
        scratch.push_back(CHAR_COLON);
        scratch.push_back(CHAR_COLON);
        put_hex_token();
      end
    end
  endtask

  task automatic gen_noise();
    int n, r;
    scratch.delete();
    n = ($urandom_range(4) == 0) ? $urandom_range(60, 90) : $urandom_range(1, 20);
    repeat (n) begin
      r = $urandom_range(9);
      if (r < 4) scratch.push_back(CHAR_COLON);
      else if (r < 8) scratch.push_back(hex_char($urandom_range(15), $urandom_range(1)));
      else scratch.push_back(8'($urandom_range(1, 255)));
    end
  endtask

  // full eight groups, then padding to the length cap and groups that must be ignored
  task automatic add_long_text();
    scratch.delete();
    for (int i = 1; i <= GROUP_SLOTS; i++) begin
      if (i > 1) scratch.push_back(CHAR_COLON);
      scratch.push_back(hex_char(i, 0));
    end
    while (scratch.size() < TEXT_LIMIT) scratch.push_back(CH_Z);
    repeat (3) begin
      scratch.push_back(CHAR_COLON);
      scratch.push_back(CH_NINE);
    end
    queue_scratch(1'b0);
  endtask

  function automatic int pick_gap(input bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
        $display("result %0d: %s expected %h got %h", results_seen, name, want, got);
    end
  endtask

  // ------------------------------------------------------ request acceptance
  always @(posedge clk) begin
    req_taken = 0;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        req_taken = 1;
        scan_char(in_text_char, in_last_char);
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (pending_addrs.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("result %0d: unexpected, addr %h_%h", results_seen,
                     out_addr_high, out_addr_low);
        end else begin
          front_addr = pending_addrs.pop_front();
          compare_field("addr_high", front_addr.hi, out_addr_high);
          compare_field("addr_low", front_addr.lo, out_addr_low);
          compare_field("parse_ok", 64'(front_addr.ok), 64'(out_parse_ok));
          compare_field("is_loopback", 64'(front_addr.loopback), 64'(out_is_loopback));
          compare_field("is_link_local", 64'(front_addr.link_local), 64'(out_is_link_local));
        end
      end
      if (req_taken || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  // ------------------------------------------------------------------ driver
  always @(negedge clk) begin
    char_req_t r;
    if (rst_n && (req_taken || !in_valid)) begin
      if ($urandom_range(49) == 0) in_steady = !in_steady;
      if (hold_cycles > 0) begin
        in_valid <= 1'b0;
        hold_cycles--;
      end else if (char_queue.size() == 0) begin
        in_valid <= 1'b0;
      end else if (char_queue[0].drain_first && pending_addrs.size() != 0) begin
        // hold off until every outstanding address has come back
        in_valid <= 1'b0;
      end else begin
        r = char_queue.pop_front();
        in_valid <= 1'b1;
        in_text_char <= r.ch;
        in_last_char <= r.last;
        hold_cycles = pick_gap(in_steady);
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (rst_n) begin
      if ($urandom_range(49) == 0) out_steady = !out_steady;
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if ($urandom_range(3) == 0) stall_left = pick_gap(out_steady);
      end
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    int directed_chars, text_idx;
    clear_scan();

    add_text("::1", 1'b0);
    add_text("fe80::1", 1'b0);
    add_text("febf::", 1'b0);
    add_text("fec0::", 1'b0);
    add_text("1:2:3:4:5:6:7:8", 1'b0);
    add_text("ffff:FFFF:aBcD:0:0:0:0:12345", 1'b0);
    add_text("0:0:0:0:0:0:0:1", 1'b0);
    add_text("1:2:3:4:5:6:7", 1'b0);
    add_text("1:2:3:4:5:6:7:8:9", 1'b0);
    add_text("1:2:3:4:5:6:7:8:", 1'b0);
    add_text(":2:3:4:5:6:7:8", 1'b1);
    add_text("1::2:3:4:5:6:7:8", 1'b0);
    add_text("1:2::3:4:5:6:7:8", 1'b0);
    add_text("1::2::3:::4", 1'b0);
    add_text("12g4:z:F:-9:0:0:0:7", 1'b0);
    add_text("::", 1'b0);
    add_text(":::", 1'b0);
    add_text("5", 1'b0);
    add_text("z", 1'b1);
    add_long_text();
    directed_chars = char_queue.size();

    text_idx = 0;
    while (char_queue.size() < directed_chars + RANDOM_CHARS) begin
      if ($urandom_range(4) == 0) gen_noise();
      else gen_well_formed();
      text_idx++;
      queue_scratch(text_idx % DRAIN_EVERY == 0);
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (!timed_out &&
           (char_queue.size() != 0 || in_valid || pending_addrs.size() != 0)) begin
      @(negedge clk);
      if (idle_cycles >= IDLE_LIMIT) timed_out = 1;
    end
    if (timed_out) $display("watchdog: nothing moved for %0d cycles", IDLE_LIMIT);
    else repeat (TAIL_CYCLES) @(negedge clk);

    if (pending_addrs.size() != 0) begin
      mismatch_count++;
      $display("%0d expected addresses never arrived", pending_addrs.size());
    end
    $display("covered %0d texts (%0d valid, %0d loopback, %0d link-local), %0d results checked",
             texts_scanned, ok_texts, loop_texts, ll_texts, results_seen);
    $display("mismatches: %0d", mismatch_count);
    if (timed_out || mismatch_count != 0) begin
      $display("ipv6_text_address_parser_unit: mismatch");
    end else begin
      $display("ipv6_text_address_parser_unit: match");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/ipv6p_pkg.sv
hdl/ipv6p_scan.sv
hdl/ipv6p_assemble.sv
hdl/ipv6_text_address_parser_unit.sv
verif/tb_ipv6_text_address_parser_unit.sv
